>>> rtl/core/iprt_pkg.sv
package iprt_pkg;

    localparam int IDLE_WORDS_DEF     = 4096;
    localparam int RECORD_ENTRIES_DEF = 256;
    localparam int COUNT_BITS_DEF     = 12;

    localparam int FRAME_W   = 55;
    localparam int IDLE_W    = 64;
    localparam int WORDS_W   = 13;
    localparam int TOTAL_W   = 32;
    localparam int SLOT_W    = 8;
    localparam int HIT_W     = 12;

    localparam logic [WORDS_W-1:0] WORDS_RST = 13'd4096;

    typedef logic [SLOT_W-1:0]  t_slot;
    typedef logic [HIT_W-1:0]   t_hit;
    typedef logic [TOTAL_W-1:0] t_total;
    typedef logic [FRAME_W-1:0] t_frame;

    typedef enum logic [1:0] {
        CMD_LOAD  = 2'd0,
        CMD_CHECK = 2'd1,
        CMD_END   = 2'd2
    } t_cmd;

    typedef enum logic [2:0] {
        ST_CHECKED = 3'd0,
        ST_ZERO    = 3'd1,
        ST_RANGE   = 3'd2,
        ST_FULL    = 3'd3,
        ST_LOADED  = 3'd4,
        ST_TOTALS  = 3'd5
    } t_status;

    typedef struct packed {
        logic [1:0]        command;
        logic [11:0]       word_index;
        logic [IDLE_W-1:0] idle_word;
        logic [63:0]       pagemap_entry;
    } t_in_beat;

    typedef struct packed {
        t_status status;
        logic    active;
        t_slot   slot_index;
        t_hit    hit_count;
        t_total  active_pages;
        t_total  walked_pages;
    } t_out_beat;

    // beat travelling down the slot chain
    typedef struct packed {
        t_out_beat beat;
        logic      lookup;
        logic      done;
        t_frame    frame;
    } t_token;

endpackage

>>> rtl/core/iprt_cell.sv
module iprt_cell #(
    parameter int IDX        = 0,
    parameter int COUNT_BITS = 12
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_adv,
    input  logic           i_vld,
    input  iprt_pkg::t_token i_tok,
    output logic           o_vld,
    output iprt_pkg::t_token o_tok,
    output logic           o_used
);
    import iprt_pkg::*;

    localparam t_slot MY_SLOT = t_slot'(IDX);

    logic                  r_vld;
    t_token                r_tok;
    logic                  r_used;
    t_frame                r_frame;
    logic [COUNT_BITS-1:0] r_hits;

    logic                  n_used;
    t_frame                n_frame;
    logic [COUNT_BITS-1:0] n_hits;
    t_token                n_tok;
    logic                  seek;
    logic                  hit;
    logic                  claim;

    always_comb begin
        seek    = i_vld && i_tok.lookup && !i_tok.done;
        hit     = seek && r_used && (r_frame == i_tok.frame);
        claim   = seek && !r_used;
        n_tok   = i_tok;
        n_used  = r_used;
        n_frame = r_frame;
        n_hits  = r_hits;
        if (hit) begin
            n_hits = (&r_hits) ? r_hits : r_hits + 1'b1;
        end else if (claim) begin
            n_used  = 1'b1;
            n_frame = i_tok.frame;
            n_hits  = '0;
        end
        if (hit || claim) begin
            n_tok.done            = 1'b1;
            n_tok.beat.slot_index = MY_SLOT;
            n_tok.beat.hit_count  = t_hit'(n_hits);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld  <= 1'b0;
            r_used <= 1'b0;
        end else if (i_adv) begin
            r_vld  <= i_vld;
            r_used <= n_used;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_tok   <= n_tok;
            r_frame <= n_frame;
            r_hits  <= n_hits;
        end
    end

    assign o_vld  = r_vld;
    assign o_tok  = r_tok;
    assign o_used = r_used;

endmodule

>>> rtl/core/iprt_front.sv
module iprt_front #(
    parameter int IDLE_WORDS = 4096
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_adv,
    input  logic                       i_in_vld,
    input  iprt_pkg::t_in_beat         i_in,
    input  logic [iprt_pkg::WORDS_W-1:0] i_words,
    output logic                       o_vld,
    output iprt_pkg::t_token           o_tok
);
    import iprt_pkg::*;

    localparam int         AW       = $clog2(IDLE_WORDS);
    localparam logic [48:0] IDLE_LIM = 49'(IDLE_WORDS);

    logic [IDLE_W-1:0] r_bitmap [IDLE_WORDS];
    logic [IDLE_W-1:0] r_rdata;

    logic     r_a_vld;
    t_in_beat r_a;
    logic     r_b_vld;
    t_in_beat r_b;
    logic     r_vld;
    t_token   r_tok;
    t_total   r_act_tot;
    t_total   r_walk_tot;

    logic     n_vld;
    t_token   n_tok;
    t_total   n_act_tot;
    t_total   n_walk_tot;

    logic          mem_we;
    logic [AW-1:0] mem_addr;
    t_frame        frame;
    logic [48:0]   word;
    logic          in_range;

    assign mem_we   = r_a_vld && (r_a.command == CMD_LOAD);
    assign mem_addr = mem_we ? AW'(r_a.word_index) : AW'(r_a.pagemap_entry[54:6]);

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            if (mem_we) begin
                r_bitmap[mem_addr] <= r_a.idle_word;
            end
            r_rdata <= r_bitmap[mem_addr];
        end
    end

    assign frame    = r_b.pagemap_entry[FRAME_W-1:0];
    assign word     = frame[54:6];
    assign in_range = (word < {36'd0, i_words}) && (word < IDLE_LIM);

    always_comb begin
        n_vld      = 1'b0;
        n_tok      = '0;
        n_act_tot  = r_act_tot;
        n_walk_tot = r_walk_tot;
        n_tok.frame = frame;
        if (r_b_vld) begin
            case (r_b.command)
                CMD_LOAD: begin
                    n_vld            = 1'b1;
                    n_tok.beat.status = ST_LOADED;
                end
                CMD_END: begin
                    n_vld            = 1'b1;
                    n_tok.beat.status = ST_TOTALS;
                    n_act_tot        = '0;
                    n_walk_tot       = '0;
                end
                CMD_CHECK: begin
                    n_vld = 1'b1;
                    if (frame == '0) begin
                        n_tok.beat.status = ST_ZERO;
                    end else if (!in_range) begin
                        n_tok.beat.status = ST_RANGE;
                    end else begin
                        n_tok.beat.status = ST_CHECKED;
                        n_walk_tot = (&r_walk_tot) ? r_walk_tot : r_walk_tot + 1'b1;
                        if (!r_rdata[frame[5:0]]) begin
                            n_act_tot = (&r_act_tot) ? r_act_tot : r_act_tot + 1'b1;
                            n_tok.beat.active = 1'b1;
                            n_tok.lookup      = 1'b1;
                        end
                    end
                end
                default: begin
                    n_vld = 1'b0;
                end
            endcase
        end
        // end of round reports the totals before clearing
        if (r_b.command == CMD_END) begin
            n_tok.beat.active_pages = r_act_tot;
            n_tok.beat.walked_pages = r_walk_tot;
        end else begin
            n_tok.beat.active_pages = n_act_tot;
            n_tok.beat.walked_pages = n_walk_tot;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld    <= 1'b0;
            r_b_vld    <= 1'b0;
            r_vld      <= 1'b0;
            r_act_tot  <= '0;
            r_walk_tot <= '0;
        end else if (i_adv) begin
            r_a_vld    <= i_in_vld;
            r_b_vld    <= r_a_vld;
            r_vld      <= n_vld;
            r_act_tot  <= n_act_tot;
            r_walk_tot <= n_walk_tot;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_a   <= i_in;
            r_b   <= r_a;
            r_tok <= n_tok;
        end
    end

    assign o_vld = r_vld;
    assign o_tok = r_tok;

endmodule

>>> rtl/core/idle_page_reference_tracker_unit.sv
// Path from input beat to result beat:
// (input stage, bitmap read, decode, the table cells in turn, output register).
// Throughput: one beat per cycle when the output is not stalled; the chain of table
// cells steps one slot a cycle. A stalled output beat freezes the whole pipeline.
// Reset (synchronous, active low): pipeline empty, table empty, totals zero,
// words-in-use 4096; the idle bitmap is undefined until loaded.
module idle_page_reference_tracker_unit #(
    parameter int IDLE_WORDS     = iprt_pkg::IDLE_WORDS_DEF,
    parameter int RECORD_ENTRIES = iprt_pkg::RECORD_ENTRIES_DEF,
    parameter int COUNT_BITS     = iprt_pkg::COUNT_BITS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    input  iprt_pkg::t_in_beat           i_in_data,
    output logic                         o_in_ready,
    output logic                         o_out_valid,
    output iprt_pkg::t_out_beat          o_out_data,
    input  logic                         i_out_ready,
    input  logic                         i_cfg_valid,
    input  logic [iprt_pkg::WORDS_W-1:0] i_cfg_data,
    output logic                         o_cfg_ready
);
    import iprt_pkg::*;

    logic               adv;
    logic [WORDS_W-1:0] r_words;
    logic               chain_vld [RECORD_ENTRIES+1];
    t_token             chain_tok [RECORD_ENTRIES+1];
    logic [RECORD_ENTRIES-1:0] used_vec;
    logic               r_out_vld;
    t_out_beat          r_out;
    t_out_beat          n_out;
    t_token             tail;

    assign adv         = !r_out_vld || i_out_ready;
    assign o_in_ready  = adv;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_words <= WORDS_RST;
        end else if (i_cfg_valid) begin
            r_words <= i_cfg_data;
        end
    end

    iprt_front #(
        .IDLE_WORDS(IDLE_WORDS)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_adv    (adv),
        .i_in_vld (i_in_valid),
        .i_in     (i_in_data),
        .i_words  (r_words),
        .o_vld    (chain_vld[0]),
        .o_tok    (chain_tok[0])
    );

    for (genvar k = 0; k < RECORD_ENTRIES; k++) begin : g_cell
        iprt_cell #(
            .IDX        (k),
            .COUNT_BITS (COUNT_BITS)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_adv   (adv),
            .i_vld   (chain_vld[k]),
            .i_tok   (chain_tok[k]),
            .o_vld   (chain_vld[k+1]),
            .o_tok   (chain_tok[k+1]),
            .o_used  (used_vec[k])
        );
    end

    assign tail = chain_tok[RECORD_ENTRIES];

    always_comb begin
        n_out = tail.beat;
        if (tail.lookup && !tail.done) begin
            n_out.status     = ST_FULL;
            n_out.slot_index = '0;
            n_out.hit_count  = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (adv) begin
            r_out_vld <= chain_vld[RECORD_ENTRIES];
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out;

`ifndef ASSERT_OFF
    a_fill_in_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((used_vec >> 1) & ~used_vec) == '0)
        else $error("table slots not filled in order");

    a_full_means_all_used: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_out_data.status == ST_FULL)) |-> (&used_vec))
        else $error("table full reported with a free slot");

    a_hits_need_active: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_out_data.hit_count != '0)) |-> o_out_data.active)
        else $error("hit count on an inactive result");

    a_freeze_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> $stable(used_vec))
        else $error("table changed while output stalled");
`endif

endmodule

>>> sim/testbench.sv
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import iprt_pkg::*;

    localparam int          WORDS          = IDLE_WORDS_DEF;
    localparam int          SLOTS          = RECORD_ENTRIES_DEF;
    localparam int          DRAIN_CYCLES   = RECORD_ENTRIES_DEF + 40;
    localparam int          HOLD_CYCLES    = 700;
    localparam int          TIMEOUT_CYCLES = 400000;
    localparam logic [1:0]  CMD_NONE       = 2'd3;
    localparam t_out_beat   NO_WANT        = '0;

    typedef struct {
        t_in_beat  beat;
        bit        typed;
        t_out_beat want;
    } t_row;

    logic                 i_clk       = 1'b0;
    logic                 i_rst_n     = 1'b0;
    logic                 i_in_valid  = 1'b0;
    t_in_beat             i_in_data   = '0;
    logic                 o_in_ready;
    logic                 o_out_valid;
    t_out_beat            o_out_data;
    logic                 i_out_ready = 1'b0;
    logic                 i_cfg_valid = 1'b0;
    logic [WORDS_W-1:0]   i_cfg_data  = '0;
    logic                 o_cfg_ready;

    // page tracking state
    logic [IDLE_W-1:0]    idle_map [WORDS];
    bit                   map_loaded [WORDS];
    logic [11:0]          loaded_words [$];
    t_frame               slot_frame [SLOTS];
    t_hit                 slot_hits [SLOTS];
    int                   slots_used   = 0;
    t_total               active_total = '0;
    t_total               walked_total = '0;
    logic [WORDS_W-1:0]   words_limit  = WORDS_RST;
    t_frame               table_frames [$];

    t_out_beat            pending_results [$];
    t_row                 plan [$];
    int                   mismatches  = 0;
    int                   results_seen = 0;
    int                   cycle_count = 0;
    int                   hold_left   = 0;
    bit                   hold_req    = 1'b0;
    bit                   calm        = 1'b0;

    idle_page_reference_tracker_unit u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_data   (i_in_data),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data),
        .i_out_ready (i_out_ready),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .o_cfg_ready (o_cfg_ready)
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= TIMEOUT_CYCLES) begin
            $display("idle_page_reference_tracker_unit verification failed");
            $finish;
        end
    end

    function automatic t_out_beat mk_out(t_status st, bit act, t_slot slot, t_hit hit,
                                         t_total ap, t_total wp);
        t_out_beat r;
        r.status       = st;
        r.active       = act;
        r.slot_index   = slot;
        r.hit_count    = hit;
        r.active_pages = ap;
        r.walked_pages = wp;
        return r;
    endfunction

    // updates the tracked state for one accepted beat; returns 1 when a result follows
    function automatic bit track_beat(input t_in_beat b, output t_out_beat r);
        t_frame frame;
        logic [11:0] word;
        r = '0;
        r.active_pages = active_total;
        r.walked_pages = walked_total;
        case (b.command)
            CMD_LOAD: begin
                idle_map[b.word_index] = b.idle_word;
                if (!map_loaded[b.word_index]) begin
                    map_loaded[b.word_index] = 1'b1;
                    loaded_words.push_back(b.word_index);
                end
                r.status = ST_LOADED;
                return 1'b1;
            end
            CMD_END: begin
                r.status     = ST_TOTALS;
                active_total = '0;
                walked_total = '0;
                return 1'b1;
            end
            CMD_CHECK: begin
                frame = b.pagemap_entry[FRAME_W-1:0];
                if (frame == '0) begin
                    r.status = ST_ZERO;
                    return 1'b1;
                end
                if ((frame >> 6) >= words_limit || (frame >> 6) >= WORDS) begin
                    r.status = ST_RANGE;
                    return 1'b1;
                end
                word = frame[17:6];
                if (walked_total != '1) walked_total++;
                r.walked_pages = walked_total;
                r.status       = ST_CHECKED;
                if (idle_map[word][frame[5:0]]) return 1'b1;
                if (active_total != '1) active_total++;
                r.active_pages = active_total;
                r.active       = 1'b1;
                for (int i = 0; i < slots_used; i++) begin
                    if (slot_frame[i] == frame) begin
                        if (slot_hits[i] != '1) slot_hits[i]++;
                        r.slot_index = t_slot'(i);
                        r.hit_count  = slot_hits[i];
                        return 1'b1;
                    end
                end
                if (slots_used < SLOTS) begin
                    slot_frame[slots_used] = frame;
                    slot_hits[slots_used]  = '0;
                    r.slot_index = t_slot'(slots_used);
                    table_frames.push_back(frame);
                    slots_used++;
                    return 1'b1;
                end
                r.status = ST_FULL;
                return 1'b1;
            end
            default: return 1'b0;
        endcase
    endfunction

    function automatic logic [63:0] draw_idle_word();
        int roll;
        roll = $urandom_range(99);
        if (roll < 15) return '0;
        if (roll < 25) return '1;
        if (roll < 40) return {$urandom, $urandom};
        return {$urandom & $urandom & $urandom, $urandom & $urandom & $urandom};
    endfunction

    function automatic t_frame draw_frame();
        t_frame f;
        int lim;
        int roll;
        logic [11:0] w;
        lim  = (words_limit > WORDS) ? WORDS : int'(words_limit);
        roll = $urandom_range(99);
        f    = '0;
        if (roll < 5) return f;
        if (roll < 13) begin
            if ($urandom_range(1) == 1) begin
                f = t_frame'({$urandom, $urandom});
                f[FRAME_W-1] = 1'b1;
            end else begin
                f[FRAME_W-1:6] = 49'(lim + $urandom_range(200));
                f[5:0]         = 6'($urandom_range(63));
            end
            return f;
        end
        if (roll < 55 && table_frames.size() > 0) begin
            f = table_frames[$urandom_range(table_frames.size() - 1)];
            if ((f >> 6) < lim) return f;
        end
        f = '0;
        if (loaded_words.size() > 0) begin
            repeat (8) begin
                w = loaded_words[$urandom_range(loaded_words.size() - 1)];
                if (w < lim) begin
                    f[17:6] = w;
                    f[5:0]  = 6'($urandom_range(63));
                    return f;
                end
            end
        end
        return f;
    endfunction

    function automatic t_in_beat draw_beat();
        t_in_beat b;
        int roll;
        b.word_index    = 12'($urandom);
        b.idle_word     = {$urandom, $urandom};
        b.pagemap_entry = {$urandom, $urandom};
        roll = $urandom_range(99);
        if (roll < 18) begin
            b.command   = CMD_LOAD;
            b.idle_word = draw_idle_word();
            if ($urandom_range(3) != 0) b.word_index = 12'($urandom_range(300));
        end else if (roll < 22) begin
            b.command = CMD_END;
        end else if (roll < 25) begin
            b.command = CMD_NONE;
        end else begin
            b.command = CMD_CHECK;
            b.pagemap_entry[FRAME_W-1:0] = draw_frame();
        end
        return b;
    endfunction

    function automatic void add_row(logic [1:0] cmd, logic [11:0] idx, logic [63:0] word,
                                    logic [63:0] entry, bit typed, t_out_beat want);
        t_row row;
        row.beat.command       = cmd;
        row.beat.word_index    = idx;
        row.beat.idle_word     = word;
        row.beat.pagemap_entry = entry;
        row.typed              = typed;
        row.want               = want;
        plan.push_back(row);
    endfunction

    function automatic void note_mismatch(string msg);
        mismatches++;
        if (mismatches <= 10) $display("%s", msg);
    endfunction

    function automatic void compare_field(string name, logic [63:0] want, logic [63:0] got);
        if (got !== want)
            note_mismatch($sformatf("result %0d %s: expected %0h got %0h",
                                    results_seen, name, want, got));
    endfunction

    task automatic take_result(input t_out_beat got);
        t_out_beat want;
        results_seen++;
        if (pending_results.size() == 0) begin
            note_mismatch($sformatf("result %0d unexpected: %0h", results_seen, got));
            return;
        end
        want = pending_results.pop_front();
        compare_field("status", 64'(want.status), 64'(got.status));
        compare_field("active", 64'(want.active), 64'(got.active));
        compare_field("slot_index", 64'(want.slot_index), 64'(got.slot_index));
        compare_field("hit_count", 64'(want.hit_count), 64'(got.hit_count));
        compare_field("active_pages", 64'(want.active_pages), 64'(got.active_pages));
        compare_field("walked_pages", 64'(want.walked_pages), 64'(got.walked_pages));
    endtask

    task automatic offer(input t_in_beat b, input bit typed, input t_out_beat want);
        t_out_beat r;
        while (!calm && $urandom_range(99) < 27) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= b;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        if (track_beat(b, r)) pending_results.push_back(typed ? want : r);
    endtask

    task automatic run_random(input int count);
        repeat (count) offer(draw_beat(), 1'b0, NO_WANT);
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        // unknown commands may still be in flight
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_limit(input logic [WORDS_W-1:0] value);
        drain();
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        words_limit = value;
    endtask

    // sink side, with random stalls and one long hold
    initial begin
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_out_valid && i_out_ready) take_result(o_out_data);
            if (hold_req) begin
                hold_req  = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= calm || ($urandom_range(99) >= 27);
            end
        end
    end

    initial begin
        add_row(CMD_END, 12'd0, 64'd0, 64'd0, 1'b1, mk_out(ST_TOTALS, 0, 0, 0, 0, 0));
        add_row(CMD_CHECK, 12'hfff, '1, 64'd0, 1'b1, mk_out(ST_ZERO, 0, 0, 0, 0, 0));
        add_row(CMD_CHECK, 12'd0, 64'd0, 64'hff80_0000_0000_0000, 1'b1,
                mk_out(ST_ZERO, 0, 0, 0, 0, 0));
        add_row(CMD_CHECK, 12'd0, 64'd0, 64'd262144, 1'b1, mk_out(ST_RANGE, 0, 0, 0, 0, 0));
        add_row(CMD_CHECK, 12'd0, 64'd0, '1, 1'b1, mk_out(ST_RANGE, 0, 0, 0, 0, 0));
        add_row(CMD_NONE, 12'h555, 64'h5555_5555_5555_5555, 64'h41, 1'b0, NO_WANT);
        add_row(CMD_LOAD, 12'd0, 64'd0, 64'd0, 1'b1, mk_out(ST_LOADED, 0, 0, 0, 0, 0));
        add_row(CMD_LOAD, 12'hfff, '1, '1, 1'b1, mk_out(ST_LOADED, 0, 0, 0, 0, 0));
        add_row(CMD_LOAD, 12'd1, 64'haaaa_aaaa_aaaa_aaaa, 64'd0, 1'b1,
                mk_out(ST_LOADED, 0, 0, 0, 0, 0));
        add_row(CMD_CHECK, 12'd0, 64'd0, 64'd1, 1'b1, mk_out(ST_CHECKED, 1, 0, 0, 1, 1));
        add_row(CMD_CHECK, 12'd0, 64'd0, 64'd1, 1'b1, mk_out(ST_CHECKED, 1, 0, 1, 2, 2));
        add_row(CMD_CHECK, 12'd0, 64'd0, 64'd262143, 1'b1, mk_out(ST_CHECKED, 0, 0, 0, 2, 3));
        add_row(CMD_CHECK, 12'd0, 64'd0, 64'hff80_0000_0000_003f, 1'b0, NO_WANT);
        add_row(CMD_CHECK, 12'd0, 64'd0, 64'd65, 1'b0, NO_WANT);
        add_row(CMD_CHECK, 12'd0, 64'd0, 64'd64, 1'b0, NO_WANT);
        add_row(CMD_LOAD, 12'h800, 64'h8000_0000_0000_0001, 64'd0, 1'b0, NO_WANT);
        add_row(CMD_CHECK, 12'd0, 64'd0, 64'd131072, 1'b0, NO_WANT);
        add_row(CMD_CHECK, 12'd0, 64'd0, 64'd131073, 1'b0, NO_WANT);
        add_row(CMD_END, 12'd0, 64'd0, 64'd0, 1'b0, NO_WANT);
        add_row(CMD_CHECK, 12'd0, 64'd0, 64'd1, 1'b0, NO_WANT);
        add_row(CMD_NONE, 12'haaa, '1, '1, 1'b0, NO_WANT);
        add_row(CMD_END, 12'd0, 64'd0, 64'd0, 1'b0, NO_WANT);

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (plan[i]) offer(plan[i].beat, plan[i].typed, plan[i].want);

        calm = 1'b1;
        run_random(150);
        calm = 1'b0;
        run_random(200);

        write_limit('0);
        run_random(80);
        write_limit('1);
        run_random(150);

        write_limit(WORDS_W'($urandom_range(1, 300)));
        hold_req = 1'b1;
        run_random(400);

        write_limit(WORDS_W'(1));
        run_random(80);

        write_limit(WORDS_RST);
        run_random(120);

        drain();
        if (mismatches == 0) begin
            $display("idle_page_reference_tracker_unit verification clean");
        end else begin
            $display("idle_page_reference_tracker_unit verification failed");
        end
        $finish;
    end

endmodule
